/* sv/hrp_pkg.sv */
// ----------------------------------------------------------------------------
// hrp_pkg: shared constants for the hsv to rgb pixel converter
// Field widths, default fraction width and hue sector codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hrp_pkg;

  // fixed field widths
  localparam int HUE_W = 16;
  localparam int SAT_W = 17;
  localparam int VAL_W = 17;
  localparam int CH_W  = 8;

  // default fixed-point fraction width
  localparam int FRAC_BITS_DEF = 16;

  // hue sectors, sixths of a turn
  localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
  localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
  localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
  localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
  localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;
  localparam logic [2:0] SECTOR_MAGENTA_RED   = 3'd5;

endpackage

`default_nettype wire

/* sv/hsv_to_rgb_pixel.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel: fixed-point hsv to rgb color conversion
// Hue, saturation and value in, 8-bit red, green and blue out, one pixel
// per clock while the output is not stalled, through a four-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid, in_ready, hue, saturation,  | in
//          | brightness                            |
//  output  | out_valid, out_ready, red, green,     | out
//          | blue                                  |
//
//  Four register stages: s1, s2, s3 and the output register, which sets
//  out_valid. One pixel is taken every cycle while the output side
//  takes its results. The stages are the clamp and hue times six, the two
//  dependent multiplies (s*f, then v*(1-s*f)), and routing into the output.
//  Each stage holds its data while the stage after it is full and stalled,
//  so a stall loses and repeats nothing. Synchronous reset empties the pipe.
//
`default_nettype none

module hsv_to_rgb_pixel #(
  parameter int FRAC_BITS = hrp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [hrp_pkg::HUE_W-1:0]  hue,
  input  wire logic [hrp_pkg::SAT_W-1:0]  saturation,
  input  wire logic [hrp_pkg::VAL_W-1:0]  brightness,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [hrp_pkg::CH_W-1:0]        red,
  output logic [hrp_pkg::CH_W-1:0]        green,
  output logic [hrp_pkg::CH_W-1:0]        blue
);

  // working widths
  localparam int FB  = FRAC_BITS;
  localparam int SW  = FB + 1;                 // holds 0 .. 1.0
  localparam int H6W = FB + 20;                // hue * 6 plus sector bits
  localparam int SCW = H6W - FB;               // sector field width
  localparam int CW  = (SW > hrp_pkg::SAT_W) ? SW : hrp_pkg::SAT_W;
  localparam int MW  = 2 * SW;
  localparam logic [SW-1:0] ONE_FX = {1'b1, {FB{1'b0}}};

  // channel byte: floor(x * 256) saturated to 255
  function automatic logic [hrp_pkg::CH_W-1:0] to_byte(input logic [SW-1:0] x);
    logic [8:0] b;
    b = x[SW-1:FB-8];
    return b[8] ? 8'hFF : b[7:0];
  endfunction

  // ---------------- stage 1: clamp, hue times six ----------------
  logic [H6W-1:0] h6;
  logic [SCW-1:0] sec_raw;
  logic [2:0]     sec_in;
  logic [CW-1:0]  s_ext;
  logic [CW-1:0]  v_ext;
  logic [SW-1:0]  s_cl;
  logic [SW-1:0]  v_cl;
  logic [FB-1:0]  f_in;

  logic           s1_valid;
  logic [SW-1:0]  s1_s;
  logic [SW-1:0]  s1_v;
  logic [FB-1:0]  s1_f;
  logic [SW-1:0]  s1_fn;
  logic [2:0]     s1_sec;

  // ---------------- stage 2: first products ----------------
  logic [SW+FB-1:0] m_sf;
  logic [MW-1:0]    m_sfn;
  logic [MW-1:0]    m_p;

  logic           s2_valid;
  logic [SW-1:0]  s2_sf;
  logic [SW-1:0]  s2_sfn;
  logic [SW-1:0]  s2_p;
  logic [SW-1:0]  s2_v;
  logic [2:0]     s2_sec;

  // ---------------- stage 3: second products ----------------
  logic [MW-1:0]  m_q;
  logic [MW-1:0]  m_t;

  logic           s3_valid;
  logic [SW-1:0]  s3_p;
  logic [SW-1:0]  s3_q;
  logic [SW-1:0]  s3_t;
  logic [SW-1:0]  s3_v;
  logic [2:0]     s3_sec;

  // ---------------- stage 4: routing ----------------
  logic [SW-1:0]  cr;
  logic [SW-1:0]  cg;
  logic [SW-1:0]  cb;

  // per-stage ready: a stage loads when empty or when its successor moves
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !s3_valid || rdy4;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign in_ready = rdy1;

  // hue * 6 as shift and add, sector and fraction
  always_comb begin
    h6      = (H6W'(hue) << 2) + (H6W'(hue) << 1);
    sec_raw = h6[H6W-1:FB];
    f_in    = h6[FB-1:0];
    // a full turn or more takes the last sector
    if (sec_raw >= SCW'(hrp_pkg::SECTOR_MAGENTA_RED)) begin
      sec_in = hrp_pkg::SECTOR_MAGENTA_RED;
    end else begin
      sec_in = sec_raw[2:0];
    end
  end

  // saturate s and v at 1.0
  always_comb begin
    s_ext = CW'(saturation);
    v_ext = CW'(brightness);
    s_cl  = (s_ext > CW'(ONE_FX)) ? ONE_FX : SW'(s_ext);
    v_cl  = (v_ext > CW'(ONE_FX)) ? ONE_FX : SW'(v_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_s   <= s_cl;
      s1_v   <= v_cl;
      s1_f   <= f_in;
      s1_fn  <= ONE_FX - SW'(f_in);
      s1_sec <= sec_in;
    end
  end

  // s*f, s*(1-f) and v*(1-s), truncated
  always_comb begin
    m_sf  = (SW+FB)'(s1_s) * (SW+FB)'(s1_f);
    m_sfn = MW'(s1_s) * MW'(s1_fn);
    m_p   = MW'(s1_v) * MW'(ONE_FX - s1_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid) begin
      s2_sf  <= m_sf[SW+FB-1:FB];
      s2_sfn <= m_sfn[SW+FB-1:FB];
      s2_p   <= m_p[SW+FB-1:FB];
      s2_v   <= s1_v;
      s2_sec <= s1_sec;
    end
  end

  // v*(1-s*f) and v*(1-s*(1-f)), truncated
  always_comb begin
    m_q = MW'(s2_v) * MW'(ONE_FX - s2_sf);
    m_t = MW'(s2_v) * MW'(ONE_FX - s2_sfn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (rdy3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_valid) begin
      s3_p   <= s2_p;
      s3_q   <= m_q[SW+FB-1:FB];
      s3_t   <= m_t[SW+FB-1:FB];
      s3_v   <= s2_v;
      s3_sec <= s2_sec;
    end
  end

  // sector routing of v, p, q, t to the channels
  // zero saturation needs no special arm: p, q and t all equal v then
  always_comb begin
    unique case (s3_sec)
      hrp_pkg::SECTOR_RED_YELLOW: begin
        cr = s3_v; cg = s3_t; cb = s3_p;
      end
      hrp_pkg::SECTOR_YELLOW_GREEN: begin
        cr = s3_q; cg = s3_v; cb = s3_p;
      end
      hrp_pkg::SECTOR_GREEN_CYAN: begin
        cr = s3_p; cg = s3_v; cb = s3_t;
      end
      hrp_pkg::SECTOR_CYAN_BLUE: begin
        cr = s3_p; cg = s3_q; cb = s3_v;
      end
      hrp_pkg::SECTOR_BLUE_MAGENTA: begin
        cr = s3_t; cg = s3_p; cb = s3_v;
      end
      default: begin
        cr = s3_v; cg = s3_p; cb = s3_q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && s3_valid) begin
      red   <= to_byte(cr);
      green <= to_byte(cg);
      blue  <= to_byte(cb);
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_hsv_to_rgb_pixel.sv */
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_pixel: self-checking bench for the hsv to rgb pixel converter
// A queue of pixels, first hand-picked corner cases and then random ones,
// feeds a valid/ready driver. A fixed-point color model predicts each byte
// triple, and a monitor compares every output transfer against it in order.
// ----------------------------------------------------------------------------

module tb_hsv_to_rgb_pixel;

  localparam int FB         = hrp_pkg::FRAC_BITS_DEF;
  localparam int UNIT       = 1 << FB;
  localparam int N_RANDOM   = 500;
  localparam int QUIET_MAX  = 2000;
  localparam int TAIL_WAIT  = 16;

  typedef struct {
    logic [hrp_pkg::HUE_W-1:0] hue;
    logic [hrp_pkg::SAT_W-1:0] sat;
    logic [hrp_pkg::VAL_W-1:0] val;
    bit                        drain_first;
  } hsv_pixel_t;

  typedef struct {
    logic [hrp_pkg::CH_W-1:0] r;
    logic [hrp_pkg::CH_W-1:0] g;
    logic [hrp_pkg::CH_W-1:0] b;
  } rgb_pixel_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [hrp_pkg::HUE_W-1:0]  hue = '0;
  logic [hrp_pkg::SAT_W-1:0]  saturation = '0;
  logic [hrp_pkg::VAL_W-1:0]  brightness = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [hrp_pkg::CH_W-1:0]   red;
  logic [hrp_pkg::CH_W-1:0]   green;
  logic [hrp_pkg::CH_W-1:0]   blue;

  hsv_pixel_t  pixels_to_send[$];
  rgb_pixel_t  rgb_expected[$];
  hsv_pixel_t  pixel_on_bus;
  int          n_total = 0;
  int          n_sent = 0;
  int          n_recv = 0;
  int          errors = 0;
  int          send_gap = 0;
  int          recv_hold = 0;
  int          quiet_cycles = 0;
  bit          sent_now;
  bit          pipe_empty;
  int          hold_draw;
  rgb_pixel_t  want;

  hsv_to_rgb_pixel #(
    .FRAC_BITS(FB)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .hue(hue),
    .saturation(saturation),
    .brightness(brightness),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .red(red),
    .green(green),
    .blue(blue)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // channel value in fixed point to a byte, clipped at full scale
  function automatic logic [hrp_pkg::CH_W-1:0] to_channel_byte(longint unsigned x);
    longint unsigned b;
    b = x >> (FB - 8);
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  // expected color for one pixel
  function automatic rgb_pixel_t hsv_to_rgb(hsv_pixel_t px);
    longint unsigned s, v, h6, sec, f, term_p, term_q, term_t, cr, cg, cb;
    rgb_pixel_t c;
    s = (px.sat > UNIT) ? UNIT : px.sat;
    v = (px.val > UNIT) ? UNIT : px.val;
    if (s == 0) begin
      c.r = to_channel_byte(v);
      c.g = c.r;
      c.b = c.r;
      return c;
    end
    h6 = longint'(px.hue) * 6;
    sec = h6 >> FB;
    f = h6 & (UNIT - 1);
    term_p = (v * (UNIT - s)) >> FB;
    term_q = (v * (UNIT - ((s * f) >> FB))) >> FB;
    term_t = (v * (UNIT - ((s * (UNIT - f)) >> FB))) >> FB;
    // sector decides which term drives which channel
    case (sec)
      hrp_pkg::SECTOR_RED_YELLOW: begin
        cr = v;      cg = term_t; cb = term_p;
      end
      hrp_pkg::SECTOR_YELLOW_GREEN: begin
        cr = term_q; cg = v;      cb = term_p;
      end
      hrp_pkg::SECTOR_GREEN_CYAN: begin
        cr = term_p; cg = v;      cb = term_t;
      end
      hrp_pkg::SECTOR_CYAN_BLUE: begin
        cr = term_p; cg = term_q; cb = v;
      end
      hrp_pkg::SECTOR_BLUE_MAGENTA: begin
        cr = term_t; cg = term_p; cb = v;
      end
      default: begin
        cr = v;      cg = term_p; cb = term_q;
      end
    endcase
    c.r = to_channel_byte(cr);
    c.g = to_channel_byte(cg);
    c.b = to_channel_byte(cb);
    return c;
  endfunction

  // unit-range value with weight on zero, full scale and the clipped range
  function automatic int rand_unit_value();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return UNIT;
      2: return int'($urandom_range(UNIT + 1, 17'h1FFFF));
      3: return int'($urandom_range(0, 255));
      default: return int'($urandom_range(0, UNIT));
    endcase
  endfunction

  task automatic queue_pixel(int h, int s, int v, bit drain_first);
    hsv_pixel_t px;
    px.hue = hrp_pkg::HUE_W'(h);
    px.sat = hrp_pkg::SAT_W'(s);
    px.val = hrp_pkg::VAL_W'(v);
    px.drain_first = drain_first;
    pixels_to_send = {pixels_to_send, px};
  endtask

  // sender: one pixel per transfer, random gaps in alternating stretches
  always @(posedge clk) begin
    sent_now = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (sent_now) begin
        rgb_expected = {rgb_expected, hsv_to_rgb(pixel_on_bus)};
        n_sent <= n_sent + 1;
      end
      if (!in_valid || sent_now) begin
        pipe_empty = (n_sent + int'(sent_now)) == n_recv;
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pixels_to_send.size() != 0 &&
                     (!pixels_to_send[0].drain_first || pipe_empty)) begin
          pixel_on_bus = pixels_to_send.pop_front();
          hue        <= pixel_on_bus.hue;
          saturation <= pixel_on_bus.sat;
          brightness <= pixel_on_bus.val;
          in_valid   <= 1'b1;
          send_gap   <= ((n_sent / 64) % 2 == 1) ? $urandom_range(0, 8) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result transfer, then in alternating stretches stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_hold <= 0;
    end else if (out_valid && out_ready) begin
      n_recv <= n_recv + 1;
      if (rgb_expected.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", red, green, blue);
        errors++;
      end else begin
        want = rgb_expected.pop_front();
        if (red !== want.r) begin
          $error("red: expected %0d, got %0d", want.r, red);
          errors++;
        end
        if (green !== want.g) begin
          $error("green: expected %0d, got %0d", want.g, green);
          errors++;
        end
        if (blue !== want.b) begin
          $error("blue: expected %0d, got %0d", want.b, blue);
          errors++;
        end
      end
      hold_draw = ((n_recv / 48) % 2 == 1) ? $urandom_range(0, 8) : 0;
      recv_hold <= hold_draw;
      out_ready <= (hold_draw == 0);
    end else if (recv_hold != 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= (recv_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    // grey, clipping and full-scale corners
    queue_pixel(0, 0, 0, 0);
    queue_pixel(0, 0, UNIT, 0);
    queue_pixel(12345, 0, 17'h1FFFF, 0);
    queue_pixel(0, UNIT, UNIT, 0);
    queue_pixel(65535, UNIT, UNIT, 0);
    queue_pixel(65535, 17'h1FFFF, 17'h1FFFF, 0);
    queue_pixel(30000, 1, 65535, 0);
    queue_pixel(50000, 65535, 1, 0);
    // both sides of every sector boundary
    queue_pixel(10922, UNIT, UNIT, 0);
    queue_pixel(10923, UNIT, UNIT, 0);
    queue_pixel(21845, 40000, 60000, 0);
    queue_pixel(21846, 40000, 60000, 0);
    queue_pixel(32767, UNIT, 65535, 0);
    queue_pixel(32768, UNIT, 65535, 0);
    queue_pixel(43690, 32768, UNIT, 0);
    queue_pixel(43691, 32768, UNIT, 0);
    queue_pixel(54613, 20000, 17'h10001, 0);
    queue_pixel(54614, 20000, 17'h10001, 0);
    // mid-sector, half saturation
    queue_pixel(5461, 32768, UNIT, 0);
    queue_pixel(16384, 32768, UNIT, 0);
    queue_pixel(27307, 32768, UNIT, 0);
    queue_pixel(38229, 32768, UNIT, 0);
    queue_pixel(49152, 32768, UNIT, 0);
    queue_pixel(60075, 32768, UNIT, 0);
    // random pixels, the pipe drained now and then
    for (int i = 0; i < N_RANDOM; i++)
      queue_pixel($urandom_range(0, 65535), rand_unit_value(), rand_unit_value(),
                  (i % 100) == 0);
    n_total = pixels_to_send.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (n_sent != n_total || n_recv != n_total) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (rgb_expected.size() != 0) begin
      $error("%0d results never arrived", rgb_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* hsv_to_rgb_pixel.f */
sv/hrp_pkg.sv
sv/hsv_to_rgb_pixel.sv
tb/sv/tb_hsv_to_rgb_pixel.sv
